[hw/rtl/qrs_pkg.sv]
// qrs_pkg: shared types, widths and helpers for the quadratic root solver
// used by quadratic_root_solver, qrs_sqrt_cell and qrs_div_cell; no dependencies
`default_nettype none

package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int TOL_WIDTH  = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd655;

    // coefficient alignment to Q16.16 for the near-zero test
    localparam int ALIGN_SHIFT = 16 - FRAC_BITS;
    // discriminant compare shifts (left side and tolerance side)
    localparam int DISC_SL = (16 - 2 * FRAC_BITS) > 0 ? (16 - 2 * FRAC_BITS) : 0;
    localparam int DISC_SR = (2 * FRAC_BITS - 16) > 0 ? (2 * FRAC_BITS - 16) : 0;

    localparam int PROD_W = 2 * COEF_WIDTH;        // b*b, a*c
    localparam int DISC_W = 2 * COEF_WIDTH + 2;    // |D|
    localparam int DISX_W = DISC_W + 1;            // signed D
    localparam int CMP_W  = DISC_W + 16;
    localparam int ROOT_W = COEF_WIDTH + 17;       // floor(sqrt(D * 2^32))
    localparam int RAD_W  = 2 * ROOT_W;            // D * 2^32
    localparam int NB_W   = COEF_WIDTH + 17;       // signed numerator base
    localparam int NUM_W  = COEF_WIDTH + 19;       // signed numerator incl. sqrt term
    localparam int NMAG_W = NUM_W - 1;
    localparam int DEN_W  = COEF_WIDTH + 2;        // signed divisor (up to 2a)
    localparam int UD_W   = DEN_W - 1;             // divisor magnitude
    localparam int DIVN_W = COEF_WIDTH + 19;       // dividend incl. rounding term
    localparam int QX_W   = DIVN_W > 33 ? DIVN_W : 33;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_LINEAR   = 3'd1,
        KIND_DOUBLE   = 3'd2,
        KIND_TWO      = 3'd3,
        KIND_INFINITE = 3'd4
    } kind_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } coef_in_t;

    typedef struct packed {
        logic signed [31:0] root_one;
        logic signed [31:0] root_two;
        logic [2:0]         solution_kind;
        logic               overflowed;
    } root_out_t;

    typedef struct packed {
        logic                     valid;
        kind_t                    kind;
        logic signed [NB_W-1:0]   nbase;
        logic signed [DEN_W-1:0]  den;
    } ctl_t;

    typedef struct packed {
        ctl_t               ctl;
        logic [RAD_W-1:0]   rad;
        logic [ROOT_W-1:0]  rem;
        logic [ROOT_W-1:0]  root;
    } sq_t;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic                neg1;
        logic                neg2;
        logic [UD_W-1:0]     ud;
        logic [DIVN_W-1:0]   x1;
        logic [DIVN_W-1:0]   x2;
        logic [UD_W-1:0]     rem1;
        logic [UD_W-1:0]     rem2;
        logic [DIVN_W-1:0]   q1;
        logic [DIVN_W-1:0]   q2;
    } dv_t;

    typedef struct packed {
        logic        ov;
        logic [31:0] val;
    } sat_t;

    function automatic logic coef_small(logic signed [COEF_WIDTH-1:0] x,
                                        logic [TOL_WIDTH-1:0] tol);
        logic [COEF_WIDTH-1:0]    m;
        logic [COEF_WIDTH+15:0]   ms;
        m  = x[COEF_WIDTH-1] ? COEF_WIDTH'(0 - x) : COEF_WIDTH'(x);
        ms = (COEF_WIDTH + 16)'(m) << ALIGN_SHIFT;
        return (m == '0) || (ms < (COEF_WIDTH + 16)'(tol));
    endfunction

    // saturate a rounded quotient magnitude with its sign to Q16.16
    function automatic sat_t sat_root(logic [DIVN_W-1:0] q, logic neg);
        logic [QX_W-1:0] qx;
        logic [QX_W-1:0] nq;
        sat_t            r;
        qx = QX_W'(q);
        nq = QX_W'(0) - qx;
        if (neg)
        begin
            r.ov  = qx > (QX_W'(1) << 31);
            r.val = r.ov ? 32'h8000_0000 : nq[31:0];
        end
        else
        begin
            r.ov  = (qx >> 31) != '0;
            r.val = r.ov ? 32'h7FFF_FFFF : qx[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/quadratic_root_solver.sv]
// quadratic_root_solver: top level, coefficient front end, sqrt and divider chains
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
// A transaction is taken at every clock edge with start high; busy is always low, so
// one equation enters per cycle. Each result appears on result for one cycle with done
// high, once its start has passed two front stages (products, discriminant), one square
// root cell per root bit, one stage forming the dividends, one divider cell per quotient
// bit, and the output register. Results come back in order and cannot be held off.
// zero_tolerance is written through cfg_we/cfg_wdata and should only change while no
// transaction is in flight.
`default_nettype none

module quadratic_root_solver (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire qrs_pkg::coef_in_t   coefs,
    input  wire logic                cfg_we,
    input  wire logic [15:0]         cfg_wdata,
    output logic                     busy,
    output logic                     done,
    output qrs_pkg::root_out_t       result
);

    localparam int CW  = qrs_pkg::COEF_WIDTH;
    localparam int RW  = qrs_pkg::ROOT_W;
    localparam int NW  = qrs_pkg::DIVN_W;
    localparam int LAT = 4 + RW + NW;

    logic [qrs_pkg::TOL_WIDTH-1:0] tol_reg;

    // stage a: products and near-zero flags
    logic                        va_reg;
    logic signed [CW-1:0]        a_reg;
    logic signed [CW-1:0]        b_reg;
    logic signed [CW-1:0]        c_reg;
    logic                        sma_reg;
    logic                        smb_reg;
    logic                        smc_reg;
    logic signed [qrs_pkg::PROD_W-1:0] bb_reg;
    logic signed [qrs_pkg::PROD_W-1:0] ac_reg;
    logic signed [qrs_pkg::PROD_W-1:0] bb_next;
    logic signed [qrs_pkg::PROD_W-1:0] ac_next;

    // stage b: discriminant and case selection
    logic signed [qrs_pkg::DISX_W-1:0] disc;
    logic [qrs_pkg::DISC_W-1:0]        dmag;
    logic                              dneg;
    logic                              dsmall;
    logic signed [qrs_pkg::NB_W-1:0]   ax;
    logic signed [qrs_pkg::NB_W-1:0]   bx;
    logic signed [qrs_pkg::NB_W-1:0]   cx;
    qrs_pkg::sq_t                      sqb_next;
    qrs_pkg::sq_t                      sq_chain [0:RW];

    // stage c: dividends
    logic signed [qrs_pkg::NUM_W-1:0]  sx;
    logic signed [qrs_pkg::NUM_W-1:0]  n1;
    logic signed [qrs_pkg::NUM_W-1:0]  n2;
    logic [qrs_pkg::NMAG_W-1:0]        m1;
    logic [qrs_pkg::NMAG_W-1:0]        m2;
    logic signed [qrs_pkg::DEN_W-1:0]  den_c;
    logic [qrs_pkg::DEN_W-1:0]         dmag_c;
    logic [qrs_pkg::UD_W-1:0]          ud;
    qrs_pkg::dv_t                      dvc_next;
    qrs_pkg::dv_t                      dv_chain [0:NW];

    // output
    qrs_pkg::sat_t                     s1;
    qrs_pkg::sat_t                     s2;
    qrs_pkg::dv_t                      dv_last;
    logic                              done_reg;
    qrs_pkg::root_out_t                result_reg;
    qrs_pkg::root_out_t                result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= qrs_pkg::TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    assign bb_next = coefs.coef_b * coefs.coef_b;
    assign ac_next = coefs.coef_a * coefs.coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= coefs.coef_a;
        b_reg   <= coefs.coef_b;
        c_reg   <= coefs.coef_c;
        sma_reg <= qrs_pkg::coef_small(coefs.coef_a, tol_reg);
        smb_reg <= qrs_pkg::coef_small(coefs.coef_b, tol_reg);
        smc_reg <= qrs_pkg::coef_small(coefs.coef_c, tol_reg);
        bb_reg  <= bb_next;
        ac_reg  <= ac_next;
    end

    always_comb
    begin
        disc   = qrs_pkg::DISX_W'(bb_reg) - (qrs_pkg::DISX_W'(ac_reg) <<< 2);
        dneg   = disc[qrs_pkg::DISX_W-1];
        dmag   = disc[qrs_pkg::DISC_W-1:0];
        dsmall = (dmag == '0) ||
                 ((qrs_pkg::CMP_W'(dmag) << qrs_pkg::DISC_SL) <
                  (qrs_pkg::CMP_W'(tol_reg) << qrs_pkg::DISC_SR));
        ax = qrs_pkg::NB_W'(a_reg);
        bx = qrs_pkg::NB_W'(b_reg);
        cx = qrs_pkg::NB_W'(c_reg);

        sqb_next           = '0;
        sqb_next.ctl.valid = va_reg;
        sqb_next.ctl.kind  = qrs_pkg::KIND_NONE;
        sqb_next.ctl.den   = qrs_pkg::DEN_W'(1);
        if (sma_reg)
        begin
            if (smb_reg)
                sqb_next.ctl.kind = smc_reg ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
            else
            begin
                sqb_next.ctl.kind  = qrs_pkg::KIND_LINEAR;
                sqb_next.ctl.nbase = -(cx <<< 16);
                sqb_next.ctl.den   = qrs_pkg::DEN_W'(b_reg);
            end
        end
        else if (dneg)
            sqb_next.ctl.kind = qrs_pkg::KIND_NONE;
        else if (dsmall)
        begin
            sqb_next.ctl.kind  = qrs_pkg::KIND_DOUBLE;
            sqb_next.ctl.nbase = -(bx <<< 15);
            sqb_next.ctl.den   = qrs_pkg::DEN_W'(a_reg);
        end
        else
        begin
            sqb_next.ctl.kind  = qrs_pkg::KIND_TWO;
            sqb_next.ctl.nbase = -(bx <<< 16);
            sqb_next.ctl.den   = qrs_pkg::DEN_W'(ax) <<< 1;
            sqb_next.rad       = {dmag, 32'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_chain[0] <= '0;
        else
            sq_chain[0] <= sqb_next;
    end

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .sq_in  (sq_chain[i]),
            .sq_out (sq_chain[i+1])
        );
    end

    always_comb
    begin
        sx     = qrs_pkg::NUM_W'($signed({1'b0, sq_chain[RW].root}));
        n1     = qrs_pkg::NUM_W'(sq_chain[RW].ctl.nbase) + sx;
        n2     = qrs_pkg::NUM_W'(sq_chain[RW].ctl.nbase) - sx;
        m1     = n1[qrs_pkg::NUM_W-1] ? qrs_pkg::NMAG_W'(0 - n1) : qrs_pkg::NMAG_W'(n1);
        m2     = n2[qrs_pkg::NUM_W-1] ? qrs_pkg::NMAG_W'(0 - n2) : qrs_pkg::NMAG_W'(n2);
        den_c  = sq_chain[RW].ctl.den;
        dmag_c = den_c[qrs_pkg::DEN_W-1] ? qrs_pkg::DEN_W'(0 - den_c) : den_c;
        ud     = dmag_c[qrs_pkg::UD_W-1:0];

        dvc_next       = '0;
        dvc_next.valid = sq_chain[RW].ctl.valid;
        dvc_next.kind  = sq_chain[RW].ctl.kind;
        dvc_next.neg1  = n1[qrs_pkg::NUM_W-1] ^ den_c[qrs_pkg::DEN_W-1];
        dvc_next.neg2  = n2[qrs_pkg::NUM_W-1] ^ den_c[qrs_pkg::DEN_W-1];
        dvc_next.ud    = ud;
        // round to nearest, ties away from zero
        dvc_next.x1    = NW'(m1) + NW'(ud >> 1);
        dvc_next.x2    = NW'(m2) + NW'(ud >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_chain[0] <= '0;
        else
            dv_chain[0] <= dvc_next;
    end

    for (genvar j = 0; j < NW; j++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .dv_in  (dv_chain[j]),
            .dv_out (dv_chain[j+1])
        );
    end

    always_comb
    begin
        dv_last = dv_chain[NW];
        s1 = qrs_pkg::sat_root(dv_last.q1, dv_last.neg1);
        s2 = qrs_pkg::sat_root(dv_last.q2, dv_last.neg2);
        result_next               = '0;
        result_next.solution_kind = dv_last.kind;
        case (dv_last.kind) inside
            qrs_pkg::KIND_LINEAR, qrs_pkg::KIND_DOUBLE:
            begin
                result_next.root_one   = s1.val;
                result_next.overflowed = s1.ov;
            end
            qrs_pkg::KIND_TWO:
            begin
                result_next.root_one   = s1.val;
                result_next.root_two   = s2.val;
                result_next.overflowed = s1.ov | s2.ov;
            end
            default:
            begin
                result_next.root_one   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_last.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result strobe missing after fixed latency");

    a_root_two_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.solution_kind != qrs_pkg::KIND_TWO |-> result.root_two == '0)
        else $error("second root set without two roots");

    a_undefined_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.solution_kind == qrs_pkg::KIND_NONE ||
                 result.solution_kind == qrs_pkg::KIND_INFINITE)
        |-> result.root_one == '0 && !result.overflowed)
        else $error("undefined root not zero");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.overflowed |->
        result.root_one == 32'sh7FFF_FFFF || result.root_one == 32'sh8000_0000 ||
        result.root_two == 32'sh7FFF_FFFF || result.root_two == 32'sh8000_0000)
        else $error("overflow flag without saturated root");

endmodule

`default_nettype wire

[hw/rtl/qrs_sqrt_cell.sv]
// qrs_sqrt_cell: one digit of the square root chain, one result bit per cell
// depends on qrs_pkg
`default_nettype none

module qrs_sqrt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire qrs_pkg::sq_t  sq_in,
    output qrs_pkg::sq_t       sq_out
);

    localparam int RW = qrs_pkg::ROOT_W;

    qrs_pkg::sq_t      sq_reg;
    qrs_pkg::sq_t      sq_next;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     diff;
    logic              ge;

    always_comb
    begin
        rem_sh  = {sq_in.rem, sq_in.rad[qrs_pkg::RAD_W-1 -: 2]};
        trial   = {sq_in.root, 2'b01};
        diff    = rem_sh - trial;
        ge      = rem_sh >= trial;
        sq_next          = sq_in;
        sq_next.rad      = sq_in.rad << 2;
        sq_next.rem      = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
        sq_next.root     = {sq_in.root[RW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_reg <= '0;
        else
            sq_reg <= sq_next;
    end

    assign sq_out = sq_reg;

endmodule

`default_nettype wire

[hw/rtl/qrs_div_cell.sv]
// qrs_div_cell: one quotient bit of both restoring divider lanes
// depends on qrs_pkg
`default_nettype none

module qrs_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire qrs_pkg::dv_t  dv_in,
    output qrs_pkg::dv_t       dv_out
);

    localparam int UW = qrs_pkg::UD_W;
    localparam int NW = qrs_pkg::DIVN_W;

    qrs_pkg::dv_t  dv_reg;
    qrs_pkg::dv_t  dv_next;
    logic [UW:0]   sh1;
    logic [UW:0]   sh2;
    logic [UW:0]   d1;
    logic [UW:0]   d2;
    logic          ge1;
    logic          ge2;

    always_comb
    begin
        sh1 = {dv_in.rem1, dv_in.x1[NW-1]};
        sh2 = {dv_in.rem2, dv_in.x2[NW-1]};
        d1  = sh1 - {1'b0, dv_in.ud};
        d2  = sh2 - {1'b0, dv_in.ud};
        ge1 = sh1 >= {1'b0, dv_in.ud};
        ge2 = sh2 >= {1'b0, dv_in.ud};
        dv_next      = dv_in;
        dv_next.x1   = dv_in.x1 << 1;
        dv_next.x2   = dv_in.x2 << 1;
        dv_next.rem1 = ge1 ? d1[UW-1:0] : sh1[UW-1:0];
        dv_next.rem2 = ge2 ? d2[UW-1:0] : sh2[UW-1:0];
        dv_next.q1   = {dv_in.q1[NW-2:0], ge1};
        dv_next.q2   = {dv_in.q2[NW-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else
            dv_reg <= dv_next;
    end

    assign dv_out = dv_reg;

endmodule

`default_nettype wire

[bench/quadratic_root_solver_checker.sv]
// quadratic_root_solver_checker: watches coefficient and root transactions, predicts roots
// depends on qrs_pkg; instantiated beside the solver by quadratic_root_solver_tb
module quadratic_root_solver_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  qrs_pkg::coef_in_t    coefs,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 done,
    input  qrs_pkg::root_out_t   result,
    output int                   fail_count,
    output int                   pending_roots,
    output int                   roots_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]          tolerance;
    qrs_pkg::root_out_t   expected_roots[$];

    function automatic logic is_near_zero(longint x);
        longint m;
        m = (x < 0) ? -x : x;
        return (m == 0) || ((m << qrs_pkg::ALIGN_SHIFT) < longint'(tolerance));
    endfunction

    function automatic longint round_quot(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic [31:0] clamp_root(longint v, inout logic ov);
        if (v > 64'sd2147483647)
        begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // floor(sqrt(d * 2^32)); d fits in 34 bits so the radicand fits in 66
    function automatic longint root_of_disc(longint d);
        logic [131:0] rad;
        logic [65:0]  r;
        logic [65:0]  t;
        rad = 132'(d) << 32;
        r = '0;
        for (int i = 40; i >= 0; i--)
        begin
            t = r | (66'd1 << i);
            if (132'(t) * 132'(t) <= rad)
                r = t;
        end
        return longint'(r);
    endfunction

    function automatic qrs_pkg::root_out_t solve_equation(qrs_pkg::coef_in_t e);
        longint a;
        longint b;
        longint c;
        longint disc;
        longint nb;
        longint s;
        logic   ov;
        qrs_pkg::root_out_t r;
        a = e.coef_a;
        b = e.coef_b;
        c = e.coef_c;
        ov = 1'b0;
        r = '0;
        if (is_near_zero(a))
        begin
            if (is_near_zero(b))
                r.solution_kind = is_near_zero(c) ? qrs_pkg::KIND_INFINITE
                                                  : qrs_pkg::KIND_NONE;
            else
            begin
                r.root_one = clamp_root(round_quot(-c * 65536, b), ov);
                r.solution_kind = qrs_pkg::KIND_LINEAR;
            end
        end
        else
        begin
            disc = b * b - 4 * a * c;
            // discriminant carries 16 fraction bits with Q8.8 inputs
            if (disc < 0)
                r.solution_kind = qrs_pkg::KIND_NONE;
            else if (disc == 0 || disc < longint'(tolerance))
            begin
                r.root_one = clamp_root(round_quot(-b * 32768, a), ov);
                r.solution_kind = qrs_pkg::KIND_DOUBLE;
            end
            else
            begin
                nb = -b * 65536;
                s = root_of_disc(disc);
                r.root_one = clamp_root(round_quot(nb + s, 2 * a), ov);
                r.root_two = clamp_root(round_quot(nb - s, 2 * a), ov);
                r.solution_kind = qrs_pkg::KIND_TWO;
            end
        end
        r.overflowed = ov;
        return r;
    endfunction

    assign pending_roots = expected_roots.size();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance <= qrs_pkg::TOL_RESET;
            fail_count <= 0;
            roots_seen <= 0;
            expected_roots.delete();
        end
        else
        begin
            if (cfg_we)
                tolerance <= cfg_wdata;
            if (start && !busy)
                expected_roots.push_back(solve_equation(coefs));
            if (done)
            begin
                roots_seen <= roots_seen + 1;
                if (expected_roots.size() == 0)
                begin
                    $error("root transaction with none expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    qrs_pkg::root_out_t x;
                    x = expected_roots.pop_front();
                    if (x !== result)
                    begin
                        fail_count <= fail_count + 1;
                        if (x.root_one !== result.root_one)
                            $error("root_one expected %0d actual %0d",
                                   x.root_one, result.root_one);
                        if (x.root_two !== result.root_two)
                            $error("root_two expected %0d actual %0d",
                                   x.root_two, result.root_two);
                        if (x.solution_kind !== result.solution_kind)
                            $error("solution_kind expected %0d actual %0d",
                                   x.solution_kind, result.solution_kind);
                        if (x.overflowed !== result.overflowed)
                            $error("overflowed expected %0d actual %0d",
                                   x.overflowed, result.overflowed);
                    end
                end
            end
        end
    end
endmodule

[bench/quadratic_root_solver_tb.sv]
// quadratic_root_solver_tb: drives coefficient transactions and tolerance settings
// depends on qrs_pkg, quadratic_root_solver and quadratic_root_solver_checker
module quadratic_root_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 72;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic cfg_we;
    logic [15:0] cfg_wdata;
    qrs_pkg::coef_in_t coefs;
    qrs_pkg::root_out_t result;
    int fail_count;
    int pending_roots;
    int roots_seen;
    int quiet_cycles;
    int equations_sent;

    quadratic_root_solver uut (
        .clk(clk), .rst_n(rst_n), .start(start), .coefs(coefs),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .busy(busy), .done(done), .result(result)
    );

    quadratic_root_solver_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .coefs(coefs),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result),
        .fail_count(fail_count), .pending_roots(pending_roots), .roots_seen(roots_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("quadratic_root_solver: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9)) inside
            0: return 16'(int'($urandom_range(0, 6)) - 3);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2: return 16'($urandom_range(0, 2)) << $urandom_range(0, 15);
            [3:4]: return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_equation(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        int gap;
        coefs <= '{coef_a: a, coef_b: b, coef_c: c};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        equations_sent++;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 2) : 0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_roots();
        start <= 1'b0;
        @(posedge clk);
        while (pending_roots != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [15:0] tol);
        cfg_we <= 1'b1;
        cfg_wdata <= tol;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] tol_list[5];
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        tol_list = '{16'd0, 16'hFFFF, 16'd655, 16'd256, 16'd1};
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        coefs = '0;
        equations_sent = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: linear, infinite, none, double, two roots, overflow, extremes
        send_equation(16'h0000, 16'h0100, 16'hFE00);
        send_equation(16'h0000, 16'h0000, 16'h0000);
        send_equation(16'h0000, 16'h0000, 16'h0100);
        send_equation(16'h0001, 16'h0001, 16'h0001);
        send_equation(16'h0100, 16'h0200, 16'h0100);
        send_equation(16'h0100, 16'h0000, 16'hFC00);
        send_equation(16'h0100, 16'h0000, 16'h0100);
        send_equation(16'h0000, 16'h0001, 16'h7FFF);
        send_equation(16'h0000, 16'h0001, 16'h8000);
        send_equation(16'h0001, 16'h7FFF, 16'h8000);
        send_equation(16'h8000, 16'h8000, 16'h7FFF);
        send_equation(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_equation(16'hFFFF, 16'h8000, 16'h0000);
        send_equation(16'h0001, 16'h0000, 16'h0000);
        send_equation(16'hFF00, 16'h0300, 16'hFE00);
        send_equation(16'h0002, 16'h0004, 16'h0002);
        drain_roots();

        foreach (tol_list[t])
        begin
            set_tolerance(tol_list[t]);
            for (int n = 0; n < 250; n++)
            begin
                a = pick_coef();
                b = pick_coef();
                c = pick_coef();
                // steer some toward real roots with a near-zero discriminant
                if ($urandom_range(0, 7) == 0)
                begin
                    b = 16'(2 * int'($urandom_range(0, 60)) - 60);
                    a = 16'($urandom_range(1, 30));
                    c = 16'((int'(signed'(b)) * int'(signed'(b))) / (4 * int'(a)));
                end
                send_equation(a, b, c);
            end
            drain_roots();
        end

        $display("covered %0d equations, %0d root transactions, %0d tolerance settings",
                 equations_sent, roots_seen, 5);
        if (fail_count == 0)
            $display("quadratic_root_solver: match");
        else
            $display("quadratic_root_solver: mismatch");
        $finish;
    end
endmodule
